FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check, disabled in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cfa_pkg.sv
// ----------------------------------------------------------------------------
// cfa_pkg
// Codes and types shared by the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_COMPACT = 2'd2;
  localparam logic [1:0] FUNC_NONE    = 2'd3;

  localparam logic [1:0] POL_FIRST   = 2'd0;
  localparam logic [1:0] POL_BEST    = 2'd1;
  localparam logic [1:0] POL_WORST   = 2'd2;
  localparam logic [1:0] POL_INVALID = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_POL   = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [12:0] size_bytes;
    logic [1:0]  fit_policy;
    logic [7:0]  owner_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status_code;
    logic [7:0]  assigned_owner;
    logic [9:0]  start_word;
    logic [10:0] length_words;
  } rsp_t;

endpackage

FILE: hdl/cfa_if.sv
// ----------------------------------------------------------------------------
// cfa_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface cfa_if #(
  parameter type T = logic
) (
  input logic clk
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/contiguous_fit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Owner-tag table allocator with first/best/worst fit, release and compact.
// ----------------------------------------------------------------------------
// One request at a time; each one walks the owner-tag RAM one word per cycle.
// After reset a clearing pass zeroes the RAM before the first request is taken.
// Allocate scans the table (first fit stops early; a bad policy skips the scan),
// fills the words placed and then responds. Release walks the table, freeing
// the owner's words. Compact walks the table copying used words down, then a
// tail pass zeroes every word above the last kept one. The RAM has a single
// read port and a single write port.
// The response is held in an output register until taken.
module contiguous_fit_allocator
  import cfa_pkg::*;
#(
  parameter int WORDS      = 1024,
  parameter int OWNER_BITS = 8
) (
  input logic clk,
  input logic rst,
  cfa_if.sink   req,
  cfa_if.source rsp
);
  `include "assert_macros.svh"

  localparam int AW = $clog2(WORDS);
  localparam int CW = AW + 1;
  localparam int NW = (CW > 12) ? CW : 12;
  localparam logic [CW-1:0] WORDS_C = CW'(WORDS);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_FILL  = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_TAIL  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state;
  req_t   cur;
  rsp_t   out_data;
  rsp_t   resp_next;
  logic   out_valid;

  logic [CW-1:0]         ridx;     // next read address
  logic [CW-1:0]         pidx;     // address of data now on rdata
  logic                  pvalid;
  logic [CW-1:0]         widx;
  logic [OWNER_BITS-1:0] rdata;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [OWNER_BITS-1:0] wdata;

  logic [OWNER_BITS-1:0] next_owner;
  logic [OWNER_BITS-1:0] tag;
  logic [11:0]           need;
  logic [CW-1:0]         hole_s, hole_len, pick, pick_len;
  logic                  found;
  logic [CW-1:0]         cnt;

  cfa_ram #(.WIDTH(OWNER_BITS), .DEPTH(WORDS)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(ridx[AW-1:0]),
    .rdata(rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  logic [OWNER_BITS:0] owner_inc;
  assign owner_inc = {1'b0, next_owner} + 1'b1;

  logic who_ok;
  assign who_ok = (cur.owner_id != 8'd0) &&
                  ({8'd0, cur.owner_id} <= 16'((1 << OWNER_BITS) - 1));

  // hole end handling: a hole closes at a used word or at the table end
  logic          hole_open;
  logic [CW-1:0] len_now;
  logic          cand_ok, take;
  always_comb begin
    len_now = hole_len;
    cand_ok = hole_open && (NW'(len_now) >= NW'(need));
    take = cand_ok && (!found ||
           (cur.fit_policy == POL_BEST && len_now < pick_len) ||
           (cur.fit_policy == POL_WORST && len_now > pick_len));
  end

  logic ff_stop;
  assign ff_stop = pvalid && (cur.fit_policy == POL_FIRST) && found;

  // compact: kept words are copied down to widx as they are read; the tail
  // pass then zeroes every word above the last kept one.
  always_comb begin
    we    = 1'b0;
    waddr = widx[AW-1:0];
    wdata = '0;
    case (state)
      S_CLEAR: we = 1'b1;
      S_FILL:  begin
        we    = 1'b1;
        wdata = tag;
      end
      S_WALK: begin
        if (pvalid) begin
          if (cur.func == FUNC_RELEASE) begin
            we    = (rdata != '0) && who_ok && (rdata == cur.owner_id[OWNER_BITS-1:0]);
            waddr = pidx[AW-1:0];
          end else begin
            we    = (rdata != '0);
            wdata = rdata;
          end
        end
      end
      S_TAIL: we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    resp_next = '0;
    case (cur.func)
      FUNC_ALLOC: begin
        resp_next.assigned_owner = 8'(tag);
        if (cur.fit_policy == POL_INVALID) begin
          resp_next.status_code = ST_BAD_POL;
        end else if (!found || need == 12'd0) begin
          resp_next.status_code = ST_NO_SPACE;
        end else begin
          resp_next.status_code  = ST_OK;
          resp_next.start_word   = 10'(pick);
          resp_next.length_words = 11'(need);
        end
      end
      FUNC_RELEASE: begin
        resp_next.length_words = 11'(cnt);
        resp_next.status_code  = (cnt == '0) ? ST_NOT_FOUND : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      widx       <= '0;
      ridx       <= '0;
      pvalid     <= 1'b0;
      out_valid  <= 1'b0;
      next_owner <= '0;
    end else begin
      if (state == S_RESP && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
        out_data  <= resp_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          widx <= widx + 1'b1;
          if (widx == WORDS_C - 1'b1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            cur       <= req.data;
            need      <= 12'((14'(req.data.size_bytes) + 14'd3) >> 2);
            ridx      <= '0;
            pvalid    <= 1'b0;
            widx      <= '0;
            cnt       <= '0;
            found     <= 1'b0;
            hole_open <= 1'b0;
            hole_len  <= '0;
            pick      <= '0;
            pick_len  <= '0;
            if (req.data.func == FUNC_ALLOC) begin
              tag <= (owner_inc[OWNER_BITS-1:0] == '0) ? OWNER_BITS'(1)
                                                       : owner_inc[OWNER_BITS-1:0];
              next_owner <= (owner_inc[OWNER_BITS-1:0] == '0) ? OWNER_BITS'(1)
                                                              : owner_inc[OWNER_BITS-1:0];
              state <= (req.data.fit_policy == POL_INVALID) ? S_RESP : S_SCAN;
            end else if (req.data.func == FUNC_RELEASE ||
                         req.data.func == FUNC_COMPACT) begin
              state <= S_WALK;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          ridx   <= ff_stop ? WORDS_C : ((ridx != WORDS_C) ? ridx + 1'b1 : ridx);
          pvalid <= !ff_stop && (ridx != WORDS_C);
          pidx   <= ridx;
          if (pvalid) begin
            if (rdata == '0) begin
              if (!hole_open) begin
                hole_s   <= pidx;
                hole_len <= CW'(1);
              end else begin
                hole_len <= hole_len + 1'b1;
              end
              hole_open <= 1'b1;
            end else begin
              hole_open <= 1'b0;
              if (take) begin
                pick <= hole_s; pick_len <= len_now; found <= 1'b1;
              end
            end
          end else if (ridx == WORDS_C) begin
            // table end: close last hole and decide
            if (take || found) begin
              if (take) begin
                pick <= hole_s;
                widx <= hole_s;
              end else begin
                widx <= pick;
              end
              cnt   <= '0;
              state <= (need == 12'd0) ? S_RESP : S_FILL;
            end else begin
              state <= S_RESP;
            end
            hole_open <= 1'b0;
            found     <= take || found;
          end
        end
        S_FILL: begin
          widx <= widx + 1'b1;
          cnt  <= cnt + 1'b1;
          if (cnt + 1'b1 == CW'(need) || CW'(widx + 1'b1) == WORDS_C) begin
            state <= S_RESP;
          end
        end
        S_WALK: begin
          if (ridx != WORDS_C) begin
            ridx <= ridx + 1'b1;
          end
          pvalid <= (ridx != WORDS_C);
          pidx   <= ridx;
          if (we) begin
            if (cur.func == FUNC_RELEASE) begin
              cnt <= cnt + 1'b1;
            end else begin
              widx <= widx + 1'b1;
            end
          end
          if (!pvalid && ridx == WORDS_C) begin
            if (cur.func == FUNC_COMPACT && widx != WORDS_C) begin
              state <= S_TAIL;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_TAIL: begin
          widx <= widx + 1'b1;
          if (widx == WORDS_C - 1'b1) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_one_req, clk, rst, req.valid && req.ready, state == S_IDLE,
    "request taken while busy")
  `ASSERT_NEXT(a_resp_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid,
    "response dropped")
  `ASSERT_IMPL(a_no_resp_clear, clk, rst, state == S_CLEAR, !out_valid,
    "response during clear")
endmodule

FILE: hdl/cfa_ram.sv
// ----------------------------------------------------------------------------
// cfa_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: tb/alloc_checker.sv
// ----------------------------------------------------------------------------
// alloc_checker
// Watches the request and response channels of the allocator, keeps its own
// owner-tag table, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alloc_checker
  import cfa_pkg::*;
#(
  parameter int WORDS = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_data,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp_data,
  output int   errors,
  output int   pending
);

  logic [7:0] tags[WORDS];
  logic [7:0] last_owner;
  rsp_t       expected_rsps[$];

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic bit find_hole(input int need, input logic [1:0] pol,
                                   output int where);
    int  i;
    int  s;
    int  len;
    int  pick_len;
    bit  found;
    i = 0;
    found = 0;
    where = 0;
    pick_len = 0;
    while (i < WORDS) begin
      if (tags[i] != 0) begin
        i++;
      end else begin
        s = i;
        while (i < WORDS && tags[i] == 0) i++;
        len = i - s;
        if (len >= need) begin
          if (pol == POL_FIRST) begin
            where = s;
            return 1;
          end
          if (!found || (pol == POL_BEST && len < pick_len) ||
              (pol == POL_WORST && len > pick_len)) begin
            where = s;
            pick_len = len;
            found = 1;
          end
        end
      end
    end
    return found;
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    int   need;
    int   where;
    int   w;
    int   cnt;
    o = '0;
    if (r.func == FUNC_ALLOC) begin
      need = (int'(r.size_bytes) + 3) / 4;
      last_owner = last_owner + 8'd1;
      if (last_owner == 0) last_owner = 8'd1;
      o.assigned_owner = last_owner;
      if (r.fit_policy == POL_INVALID) begin
        o.status_code = ST_BAD_POL;
      end else if (need == 0 || need > WORDS || !find_hole(need, r.fit_policy, where)) begin
        o.status_code = ST_NO_SPACE;
      end else begin
        for (int k = 0; k < need; k++) tags[where + k] = last_owner;
        o.start_word = where[9:0];
        o.length_words = need[10:0];
      end
    end else if (r.func == FUNC_RELEASE) begin
      cnt = 0;
      if (r.owner_id != 0) begin
        for (int k = 0; k < WORDS; k++) begin
          if (tags[k] == r.owner_id) begin
            tags[k] = 0;
            cnt++;
          end
        end
      end
      o.length_words = cnt[10:0];
      if (cnt == 0) o.status_code = ST_NOT_FOUND;
    end else if (r.func == FUNC_COMPACT) begin
      w = 0;
      for (int k = 0; k < WORDS; k++) begin
        if (tags[k] != 0) begin
          tags[w] = tags[k];
          if (w != k) tags[k] = 0;
          w++;
        end
      end
    end
    return o;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    last_owner = 0;
    foreach (tags[i]) tags[i] = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready) expected_rsps.push_back(apply_request(req_data));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected response", 1, 0);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_data.status_code != want.status_code)
            report("status_code", rsp_data.status_code, want.status_code);
          if (rsp_data.assigned_owner != want.assigned_owner)
            report("assigned_owner", rsp_data.assigned_owner, want.assigned_owner);
          if (rsp_data.start_word != want.start_word)
            report("start_word", rsp_data.start_word, want.start_word);
          if (rsp_data.length_words != want.length_words)
            report("length_words", rsp_data.length_words, want.length_words);
        end
      end
    end
    pending <= expected_rsps.size();
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, release, compact and FUNC_NONE requests into the allocator with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import cfa_pkg::*;

  localparam int  N_RANDOM    = 270;
  localparam int  CYCLE_LIMIT = 2_500_000;

  logic clk = 0;
  logic rst = 1;
  int   errors;
  int   pending;
  int   cycles = 0;
  int   send_idle = 0;
  int   recv_idle = 0;
  bit   hold_off = 0;

  cfa_if #(.T(req_t)) req_ch (.clk(clk));
  cfa_if #(.T(rsp_t)) rsp_ch (.clk(clk));

  contiguous_fit_allocator dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  alloc_checker u_checker (
    .clk(clk),
    .rst(rst),
    .req_valid(req_ch.valid),
    .req_ready(req_ch.ready),
    .req_data(req_ch.data),
    .rsp_valid(rsp_ch.valid),
    .rsp_ready(rsp_ch.ready),
    .rsp_data(rsp_ch.data),
    .errors(errors),
    .pending(pending)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off while the sender keeps going
  initial begin
    rsp_ch.ready = 0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(input req_t r);
    req_ch.valid <= 1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 0;
      @(negedge clk);
    end
  endtask

  function automatic req_t make_req(input logic [1:0] f, input int sz,
                                    input logic [1:0] pol, input int who);
    req_t r;
    r.func = f;
    r.size_bytes = sz[12:0];
    r.fit_policy = pol;
    r.owner_id = who[7:0];
    return r;
  endfunction

  function automatic req_t random_req();
    int   pick;
    int   sz;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) sz = $urandom_range(8191);
    else if ($urandom_range(4) == 0) sz = $urandom_range(4096);
    else sz = $urandom_range(600);
    if (pick < 55)
      return make_req(FUNC_ALLOC, sz, ($urandom_range(19) == 0) ? POL_INVALID
                      : 2'($urandom_range(2)), $urandom_range(255));
    if (pick < 85)
      return make_req(FUNC_RELEASE, $urandom_range(8191), 2'($urandom_range(3)),
                      ($urandom_range(9) == 0) ? $urandom_range(255)
                      : $urandom_range(1, 40));
    if (pick < 97)
      return make_req(FUNC_COMPACT, $urandom_range(8191), 2'($urandom_range(3)),
                      $urandom_range(255));
    return make_req(FUNC_NONE, $urandom_range(8191), 2'($urandom_range(3)),
                    $urandom_range(255));
  endfunction

  initial begin
    req_ch.valid = 0;
    req_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send_idle = 17;
    recv_idle = 70;
    // directed: fits, holes, bad policy, bad sizes, releases, compact
    send(make_req(FUNC_ALLOC, 0, POL_FIRST, 0));
    send(make_req(FUNC_ALLOC, 1, POL_FIRST, 0));
    send(make_req(FUNC_ALLOC, 400, POL_BEST, 0));
    send(make_req(FUNC_ALLOC, 40, POL_WORST, 0));
    send(make_req(FUNC_ALLOC, 100, POL_FIRST, 0));
    send(make_req(FUNC_ALLOC, 12, POL_FIRST, 0));
    send(make_req(FUNC_RELEASE, 0, POL_FIRST, 3));
    send(make_req(FUNC_RELEASE, 0, POL_FIRST, 5));
    send(make_req(FUNC_ALLOC, 8, POL_BEST, 0));
    send(make_req(FUNC_ALLOC, 8, POL_WORST, 0));
    send(make_req(FUNC_ALLOC, 8, POL_INVALID, 0));
    send(make_req(FUNC_ALLOC, 0, POL_INVALID, 0));
    send(make_req(FUNC_ALLOC, 8191, POL_FIRST, 0));
    send(make_req(FUNC_ALLOC, 4096, POL_FIRST, 0));
    send(make_req(FUNC_RELEASE, 8191, POL_INVALID, 0));
    send(make_req(FUNC_RELEASE, 0, POL_FIRST, 255));
    send(make_req(FUNC_COMPACT, 0, POL_FIRST, 0));
    send(make_req(FUNC_NONE, 8191, POL_INVALID, 255));
    send(make_req(FUNC_ALLOC, 4096, POL_WORST, 255));
    send(make_req(FUNC_RELEASE, 0, POL_FIRST, 2));
    send(make_req(FUNC_COMPACT, 0, POL_FIRST, 0));

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle = 70;
        recv_idle = 17;
      end else if (n == 2 * N_RANDOM / 3) begin
        send_idle = 0;
        recv_idle = 0;
        fork
          begin
            hold_off = 1;
            repeat (12000) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      send(random_req());
    end
    req_ch.valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/cfa_pkg.sv
hdl/cfa_if.sv
hdl/cfa_ram.sv
hdl/contiguous_fit_allocator.sv
tb/alloc_checker.sv
tb/testbench.sv
